// ----- sv/wsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the task dispatcher
// Request and status codes, field widths and ring geometry.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int RING_SLOTS  = 4096;  // slots per ring, one always left free
  localparam int MAX_WORKERS = 8;
  localparam int HANDLE_BITS = 32;
  localparam int RING_COUNT  = MAX_WORKERS + 1;
  localparam int GLOBAL_RING = MAX_WORKERS;
  localparam int RING_W      = $clog2(RING_COUNT);

  localparam int REQ_W   = 2;
  localparam int WHO_W   = 3;
  localparam int ACT_W   = 4;
  localparam int STAT_W  = 3;
  localparam int QIDX_W  = 4;
  localparam int COUNT_W = 20;

  localparam logic [ACT_W-1:0]   ACTIVE_RESET = ACT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_SPAWN = 2'd0,
    REQ_WORK  = 2'd1,
    REQ_DONE  = 2'd2
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_LOCAL   = 3'd0,
    ST_GLOBAL  = 3'd1,
    ST_INLINE  = 3'd2,
    ST_GRANTED = 3'd3,
    ST_NONE    = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

endpackage

// ----- sv/wsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_if: valid/ready channels of the task dispatcher
// Request, response and configuration channels with source and sink views.
// ----------------------------------------------------------------------------
interface wsd_req_if import wsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [REQ_W-1:0]       req_type;
  logic [HANDLE_BITS-1:0] task_handle;
  logic [WHO_W-1:0]       requester;

  modport source (output valid, req_type, task_handle, requester, input ready);
  modport sink   (input valid, req_type, task_handle, requester, output ready);
endinterface

interface wsd_rsp_if import wsd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STAT_W-1:0]      status;
  logic [HANDLE_BITS-1:0] handle_out;
  logic [QIDX_W-1:0]      queue_index;
  logic [COUNT_W-1:0]     outstanding;

  modport source (output valid, status, handle_out, queue_index, outstanding,
                  input ready);
  modport sink   (input valid, status, handle_out, queue_index, outstanding,
                  output ready);
endinterface

interface wsd_cfg_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] active_workers;

  modport source (output valid, active_workers, input ready);
  modport sink   (input valid, active_workers, output ready);
endinterface

// ----- sv/work_stealing_task_dispatcher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_core: per-worker ring queues with stealing
//
//   channel  dir  carries
//   req      in   req_type, task_handle, requester
//   rsp      out  status, handle_out, queue_index, outstanding
//   cfg      in   active_workers
//
// Each request passes two states: exec decides and accesses the ring memory
// (single port, one read or write), then finish moves the registered read
// data to the response register. The next request is taken in the finish
// state when the response register is free. A stalled rsp holds the block in
// its finish state. Synchronous reset (rst) clears pointers and counters and
// loads ACTIVE_RESET workers; ring contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module work_stealing_task_dispatcher_core import wsd_pkg::*; #(
  parameter int QUEUE_DEPTH = RING_SLOTS
) (
  input  logic      clk,
  input  logic      rst,
  wsd_req_if.sink   req,
  wsd_rsp_if.source rsp,
  wsd_cfg_if.sink   cfg
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int MEM_D  = RING_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [RING_W-1:0] GLOB_IDX = RING_W'(GLOBAL_RING);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_t;

  state_t state;

  // request registers
  logic [REQ_W-1:0]       q_type;
  logic [HANDLE_BITS-1:0] q_handle;
  logic [WHO_W-1:0]       q_who;

  logic [ACT_W-1:0]   active_workers;
  logic [PTR_W-1:0]   head [RING_COUNT];
  logic [PTR_W-1:0]   tail [RING_COUNT];
  logic [WHO_W-1:0]   rr;
  logic [COUNT_W-1:0] pending;

  // result of the decide cycle
  logic [STAT_W-1:0]      res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [RING_W-1:0]      res_ring;

  // response register
  logic                   out_valid;
  logic [STAT_W-1:0]      out_status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [QIDX_W-1:0]      out_qidx;
  logic [COUNT_W-1:0]     out_count;

  logic [HANDLE_BITS-1:0] ring_store [MEM_D];
  logic [HANDLE_BITS-1:0] rd_data;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    ptr_adv = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // ---------------------------------------------------------------- decide
  logic [ACT_W-1:0]      n_act;
  logic [RING_W-1:0]     target;
  logic [WHO_W-1:0]      rr_next;
  logic [RING_COUNT-1:0] nonempty;
  logic [RING_W-1:0]     who_ring;
  logic                  found;
  logic [RING_W-1:0]     src;
  logic [RING_W-1:0]     hsel;
  logic [PTR_W-1:0]      head_sel, tail_tgt;
  logic                  local_ok, global_ok;
  logic                  mem_we, mem_re;
  logic [RING_W-1:0]     mem_ring;
  logic [PTR_W-1:0]      mem_ptr;
  logic [ADDR_W-1:0]     mem_addr;
  logic [STAT_W-1:0]     dec_status;
  logic [RING_W-1:0]     dec_ring;
  logic [COUNT_W-1:0]    pending_next;

  always_comb begin
    if (active_workers == '0) begin
      n_act = ACT_W'(1);
    end else if (active_workers > ACT_W'(MAX_WORKERS)) begin
      n_act = ACT_W'(MAX_WORKERS);
    end else begin
      n_act = active_workers;
    end
    target  = (ACT_W'(rr) < n_act) ? RING_W'(rr) : '0;
    rr_next = (ACT_W'(target) + ACT_W'(1) >= n_act) ? '0 : WHO_W'(target + RING_W'(1));

    for (int q = 0; q < RING_COUNT; q++) begin
      nonempty[q] = (head[q] != tail[q]);
    end

    // own ring first, then other active workers by index, then global
    who_ring = RING_W'(q_who);
    found    = 1'b0;
    src      = '0;
    if (who_ring < RING_W'(MAX_WORKERS) && nonempty[who_ring]) begin
      found = 1'b1;
      src   = who_ring;
    end
    for (int i = 0; i < MAX_WORKERS; i++) begin
      if (!found && nonempty[i] && ACT_W'(i) < n_act && RING_W'(i) != who_ring) begin
        found = 1'b1;
        src   = RING_W'(i);
      end
    end
    if (!found && nonempty[GLOBAL_RING]) begin
      found = 1'b1;
      src   = GLOB_IDX;
    end

    hsel      = (q_type == REQ_SPAWN) ? target : src;
    head_sel  = head[hsel];
    tail_tgt  = tail[target];
    local_ok  = (ptr_adv(tail_tgt) != head_sel);
    global_ok = (ptr_adv(tail[GLOBAL_RING]) != head[GLOBAL_RING]);

    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_ring     = src;
    mem_ptr      = head_sel;
    dec_status   = ST_NONE;
    dec_ring     = '0;
    pending_next = pending;
    case (q_type)
      REQ_SPAWN: begin
        if (local_ok) begin
          dec_status = ST_LOCAL;
          dec_ring   = target;
          mem_ring   = target;
          mem_ptr    = tail_tgt;
          mem_we     = 1'b1;
        end else if (global_ok) begin
          dec_status = ST_GLOBAL;
          dec_ring   = GLOB_IDX;
          mem_ring   = GLOB_IDX;
          mem_ptr    = tail[GLOBAL_RING];
          mem_we     = 1'b1;
        end else begin
          dec_status = ST_INLINE;
        end
        if (mem_we && pending != COUNT_MAX) begin
          pending_next = pending + COUNT_W'(1);
        end
      end
      REQ_WORK: begin
        if (found) begin
          dec_status = ST_GRANTED;
          dec_ring   = src;
          mem_re     = 1'b1;
        end
      end
      REQ_DONE: begin
        dec_status = ST_DONE;
        if (pending != '0) begin
          pending_next = pending - COUNT_W'(1);
        end
      end
      default: ;
    endcase
    mem_addr = ADDR_W'(mem_ring) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(mem_ptr);
  end

  // ---------------------------------------------------------------- ring memory
  always_ff @(posedge clk) begin
    if (state == S_EXEC && mem_we) begin
      ring_store[mem_addr] <= q_handle;
    end
    if (state == S_EXEC && mem_re) begin
      rd_data <= ring_store[mem_addr];
    end
  end

  // ---------------------------------------------------------------- control
  logic out_free, take;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) || (state == S_FIN && out_free);
  assign take      = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      rr             <= '0;
      pending        <= '0;
      active_workers <= ACTIVE_RESET;
      for (int q = 0; q < RING_COUNT; q++) begin
        head[q] <= '0;
        tail[q] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        active_workers <= cfg.active_workers;
      end
      // the finish state handles the response register on its own
      if (state != S_FIN && out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= dec_status;
          res_ring   <= dec_ring;
          res_handle <= (q_type == REQ_SPAWN) ? q_handle : '0;
          pending    <= pending_next;
          if (q_type == REQ_SPAWN) begin
            rr <= rr_next;
          end
          if (mem_we) begin
            tail[mem_ring] <= ptr_adv(mem_ptr);
          end
          if (mem_re) begin
            head[mem_ring] <= ptr_adv(mem_ptr);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_handle <= (res_status == ST_GRANTED) ? rd_data : res_handle;
            out_qidx   <= QIDX_W'(res_ring);
            out_count  <= pending;
            state      <= take ? S_EXEC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (take) begin
      q_type   <= req.req_type;
      q_handle <= req.task_handle;
      q_who    <= req.requester;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.handle_out  = out_handle;
  assign rsp.queue_index = out_qidx;
  assign rsp.outstanding = out_count;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for work_stealing_task_dispatcher_core
// Drives spawn, work and completion requests with random gaps on both sides.
// A mirror of the rings, round-robin pointer and outstanding count predicts
// each response, and every response transfer is checked field by field.
// ----------------------------------------------------------------------------
module testbench import wsd_pkg::*; ();

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 2000000;
  localparam int               RING_HOLD   = RING_SLOTS - 1;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_BITS-1:0] handle;
    logic [QIDX_W-1:0]    qidx;
    logic [COUNT_W-1:0]   count;
  } dispatch_rsp_t;

  // Mirror of the dispatcher: ring contents, pointers, count and the
  // responses still owed by the block.
  class dispatcher_mirror;
    logic [HANDLE_BITS-1:0] ring_copy [RING_COUNT][$];
    int unsigned            rr_next;
    logic [ACT_W-1:0]       active;
    logic [COUNT_W-1:0]     pending;
    dispatch_rsp_t          owed [$];
    int                     failures;

    function new();
      rr_next  = 0;
      active   = ACTIVE_RESET;
      pending  = '0;
      failures = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] v);
      active = v;
    endfunction

    function int unsigned workers_in_use();
      if (active == 0) return 1;
      if (active > MAX_WORKERS) return MAX_WORKERS;
      return active;
    endfunction

    function int owed_count();
      return owed.size();
    endfunction

    // Applies one accepted request and queues the response it must cause.
    function status_t take_request(logic [REQ_W-1:0] kind,
                                   logic [HANDLE_BITS-1:0] handle,
                                   logic [WHO_W-1:0] who);
      dispatch_rsp_t e;
      int unsigned   n, target;
      int            i;
      bit            got;
      e = '{status: ST_NONE, handle: '0, qidx: '0, count: '0};
      n = workers_in_use();
      got = 1'b0;
      case (kind)
        REQ_SPAWN: begin
          target  = (rr_next < n) ? rr_next : 0;
          rr_next = (target + 1 >= n) ? 0 : target + 1;
          e.handle = handle;
          if (ring_copy[target].size() < RING_HOLD) begin
            ring_copy[target].push_back(handle);
            e.status = ST_LOCAL;
            e.qidx   = QIDX_W'(target);
          end else if (ring_copy[GLOBAL_RING].size() < RING_HOLD) begin
            ring_copy[GLOBAL_RING].push_back(handle);
            e.status = ST_GLOBAL;
            e.qidx   = QIDX_W'(GLOBAL_RING);
          end else begin
            e.status = ST_INLINE;
          end
          // run-inline is counted in and out at once
          if (e.status != ST_INLINE && pending != COUNT_MAX) pending++;
        end
        REQ_WORK: begin
          // own ring first, even when the requester is not active
          if (ring_copy[who].size() != 0) begin
            e.handle = ring_copy[who].pop_front();
            e.qidx   = QIDX_W'(who);
            got = 1'b1;
          end
          for (i = 0; i < n && !got; i++) begin
            if (i != who && ring_copy[i].size() != 0) begin
              e.handle = ring_copy[i].pop_front();
              e.qidx   = QIDX_W'(i);
              got = 1'b1;
            end
          end
          if (!got && ring_copy[GLOBAL_RING].size() != 0) begin
            e.handle = ring_copy[GLOBAL_RING].pop_front();
            e.qidx   = QIDX_W'(GLOBAL_RING);
            got = 1'b1;
          end
          if (got) e.status = ST_GRANTED;
        end
        REQ_DONE: begin
          if (pending != 0) pending--;
          e.status = ST_DONE;
        end
        default: ;
      endcase
      e.count = pending;
      owed.push_back(e);
      return e.status;
    endfunction

    function void check_response(logic [STAT_W-1:0] st, logic [HANDLE_BITS-1:0] h,
                                 logic [QIDX_W-1:0] q, logic [COUNT_W-1:0] c);
      dispatch_rsp_t e;
      if (owed.size() == 0) begin
        $error("unexpected response transfer: status %0d handle %h", st, h);
        failures++;
        return;
      end
      e = owed.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        failures++;
      end
      if (h !== e.handle) begin
        $error("handle_out: expected %h, got %h", e.handle, h);
        failures++;
      end
      if (q !== e.qidx) begin
        $error("queue_index: expected %0d, got %0d", e.qidx, q);
        failures++;
      end
      if (c !== e.count) begin
        $error("outstanding: expected %0d, got %0d", e.count, c);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  wsd_req_if req_ch ();
  wsd_rsp_if rsp_ch ();
  wsd_cfg_if cfg_ch ();

  work_stealing_task_dispatcher_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  dispatcher_mirror mirror = new();

  int          send_idle_pct;
  int          rsp_stall_pct;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      mirror.check_response(rsp_ch.status, rsp_ch.handle_out, rsp_ch.queue_index,
                            rsp_ch.outstanding);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Holds valid through back-to-back requests; lowers it only for a gap.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [HANDLE_BITS-1:0] h,
                          input logic [WHO_W-1:0] who, output status_t st);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.task_handle <= h;
    req_ch.requester   <= who;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    st = mirror.take_request(kind, h, who);
  endtask

  // Sender holds off until every owed response has been transferred.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.owed_count() != 0);
  endtask

  task automatic reconfigure(input logic [ACT_W-1:0] v);
    wait_drained();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.active_workers <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    mirror.set_active(v);
  endtask

  task automatic run_random(input int items);
    logic [REQ_W-1:0] kind;
    int unsigned      pick;
    status_t          st;
    int               i;
    for (i = 1; i <= items; i++) begin
      if (i % 110 == 0) reconfigure(ACT_W'($urandom_range(15)));
      if (i == items / 2) wait_drained();
      pick = $urandom_range(99);
      kind = (pick < 40) ? REQ_SPAWN : (pick < 75) ? REQ_WORK :
             (pick < 95) ? REQ_DONE : REQ_UNUSED;
      send_req(kind, $urandom(), WHO_W'($urandom_range(7)), st);
    end
  endtask

  initial begin
    status_t st;
    int      n;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= '0;
    req_ch.task_handle    <= '0;
    req_ch.requester      <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.active_workers <= ACTIVE_RESET;
    send_idle_pct = 35;
    rsp_stall_pct = 54;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty dispatcher, completion at zero, unused code, spawn extremes
    send_req(REQ_WORK,   '0,            3'd0, st);
    send_req(REQ_DONE,   '0,            3'd0, st);
    send_req(REQ_UNUSED, 32'hFFFFFFFF,  3'd7, st);
    send_req(REQ_SPAWN,  32'h00000000,  3'd0, st);
    send_req(REQ_SPAWN,  32'hFFFFFFFF,  3'd7, st);
    send_req(REQ_SPAWN,  32'hA5A5A5A5,  3'd0, st);
    // round-robin pointer now at 3, beyond the new active count
    reconfigure(4'd2);
    send_req(REQ_SPAWN,  32'h5A5A5A5A,  3'd0, st);
    send_req(REQ_SPAWN,  32'h12345678,  3'd0, st);
    send_req(REQ_WORK,   '0,            3'd7, st);
    send_req(REQ_WORK,   '0,            3'd2, st);
    send_req(REQ_WORK,   '0,            3'd3, st);
    send_req(REQ_WORK,   '0,            3'd1, st);
    send_req(REQ_WORK,   '0,            3'd0, st);
    send_req(REQ_WORK,   '0,            3'd0, st);
    send_req(REQ_DONE,   '0,            3'd0, st);
    send_req(REQ_DONE,   '0,            3'd0, st);
    reconfigure(4'd0);
    send_req(REQ_SPAWN,  32'hDEADBEEF,  3'd0, st);
    send_req(REQ_SPAWN,  32'h0F0F0F0F,  3'd0, st);
    send_req(REQ_WORK,   '0,            3'd7, st);
    reconfigure(4'd15);
    for (n = 0; n < 9; n++) send_req(REQ_SPAWN, $urandom(), 3'd0, st);
    send_req(REQ_WORK,   '0,            3'd7, st);

    run_random(300);

    send_idle_pct = 54;
    rsp_stall_pct = 35;
    run_random(300);

    send_idle_pct = 0;
    rsp_stall_pct = 0;
    // one active worker: a back-to-back burst of spawns into worker 0
    reconfigure(4'd1);
    for (n = 0; n < 64; n++) begin
      send_req(REQ_SPAWN, $urandom(), WHO_W'($urandom_range(7)), st);
    end
    // drain through own rings, steals and the global ring until nothing is left, at most 160 requests
    for (n = 0; n < 160 && st != ST_NONE; n++) begin
      send_req(REQ_WORK, $urandom(), WHO_W'($urandom_range(7)), st);
    end
    reconfigure(4'd8);
    run_random(300);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mirror.failures == 0 && mirror.owed_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- work_stealing_task_dispatcher_core.f -----
sv/wsd_pkg.sv
sv/wsd_if.sv
sv/work_stealing_task_dispatcher_core.sv
sim/testbench.sv
